/* sv/pts_pkg.sv */
// Shared types and codes for the periodic timer slot table.
package pts_pkg;

    localparam int MAX_OUT = 16;
    localparam int WORD_W  = 88;

    localparam logic [1:0] K_ADD_PERIODIC = 2'd0;
    localparam logic [1:0] K_ADD_ONE_SHOT = 2'd1;
    localparam logic [1:0] K_REMOVE       = 2'd2;
    localparam logic [1:0] K_DISPATCH     = 2'd3;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_REMOVED = 3'd2;
    localparam logic [2:0] ST_FIRED   = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REMOVE,
        S_DISP,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
        logic add_commit;
        logic add_full;
        logic remove_do;
        logic fire;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic slot_due;
        logic idx_end;
        logic cnt_last;
        logic hold_valid;
        logic out_free;
    } t_dp_status;

endpackage

/* sv/pts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/pts_ctrl.sv */
// Sequencing state machine for add, remove and dispatch scans.
module pts_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [1:0]            i_kind,
    input  pts_pkg::t_dp_status   i_status,
    output logic                  o_stall,
    output pts_pkg::t_dp_cmd      o_cmd
);

    pts_pkg::t_state r_state;
    pts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pts_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_kind inside {pts_pkg::K_ADD_PERIODIC, pts_pkg::K_ADD_ONE_SHOT}) begin
                        n_state = pts_pkg::S_ADD;
                    end else if (i_kind == pts_pkg::K_REMOVE) begin
                        n_state = pts_pkg::S_REMOVE;
                    end else begin
                        n_state = pts_pkg::S_DISP;
                    end
                end
            end
            pts_pkg::S_ADD: begin
                if ((i_status.slot_free || i_status.idx_end) && i_status.out_free) begin
                    n_state = pts_pkg::S_IDLE;
                end
            end
            pts_pkg::S_REMOVE: begin
                if (i_status.out_free) begin
                    n_state = pts_pkg::S_IDLE;
                end
            end
            pts_pkg::S_DISP: begin
                if (i_status.slot_due) begin
                    if ((!i_status.hold_valid || i_status.out_free)
                        && (i_status.cnt_last || i_status.idx_end)) begin
                        n_state = pts_pkg::S_FLUSH;
                    end
                end else if (i_status.idx_end) begin
                    n_state = pts_pkg::S_FLUSH;
                end
            end
            pts_pkg::S_FLUSH: begin
                if (i_status.out_free) begin
                    n_state = pts_pkg::S_IDLE;
                end
            end
            default: n_state = pts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != pts_pkg::S_IDLE);
        case (r_state)
            pts_pkg::S_IDLE: begin
                o_cmd.load = i_valid;
            end
            pts_pkg::S_ADD: begin
                if (i_status.slot_free) begin
                    o_cmd.add_commit = i_status.out_free;
                end else if (i_status.idx_end) begin
                    o_cmd.add_full = i_status.out_free;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            pts_pkg::S_REMOVE: begin
                o_cmd.remove_do = i_status.out_free;
            end
            pts_pkg::S_DISP: begin
                if (i_status.slot_due) begin
                    if (!i_status.hold_valid || i_status.out_free) begin
                        o_cmd.fire    = 1'b1;
                        o_cmd.advance = !(i_status.cnt_last || i_status.idx_end);
                    end
                end else begin
                    o_cmd.advance = !i_status.idx_end;
                end
            end
            pts_pkg::S_FLUSH: begin
                o_cmd.flush = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.add_commit, o_cmd.add_full, o_cmd.remove_do, o_cmd.fire, o_cmd.flush}))
        else $error("more than one slot operation in a cycle");

    a_disp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pts_pkg::S_DISP && o_cmd.fire && i_status.cnt_last)
        |=> (r_state == pts_pkg::S_FLUSH))
        else $error("dispatch kept scanning after the last allowed fire");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != pts_pkg::S_IDLE))
        else $error("accepted transaction did not start a sequence");

endmodule

/* sv/pts_dp.sv */
// Slot table datapath: flags, slot RAM, scan index, hold stage and result register.
module pts_dp #(
    parameter int SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pts_pkg::t_dp_cmd      i_cmd,
    input  logic [1:0]            i_kind,
    input  logic [23:0]           i_interval_ms,
    input  logic [3:0]            i_slot,
    input  logic [31:0]           i_tag,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_stall,
    output pts_pkg::t_dp_status   o_status,
    output logic                  o_valid,
    output logic [2:0]            o_status_code,
    output logic [3:0]            o_slot_id,
    output logic [31:0]           o_fired_tag,
    output logic                  o_last
);

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(pts_pkg::MAX_OUT + 1);

    logic [1:0]              r_kind;
    logic [23:0]             r_ivl;
    logic [3:0]              r_slot;
    logic [31:0]             r_tag;
    logic [31:0]             r_now;
    logic [IW-1:0]           r_idx;
    logic [IW-1:0]           n_idx;
    logic [CW-1:0]           r_cnt;
    logic [SLOTS-1:0]        r_in_use;
    logic [SLOTS-1:0]        r_one_shot;
    logic                    r_hold_valid;
    logic [IW-1:0]           r_hold_idx;
    logic [31:0]             r_hold_tag;
    logic                    r_o_valid;
    logic [2:0]              r_o_status;
    logic [3:0]              r_o_slot;
    logic [31:0]             r_o_tag;
    logic                    r_o_last;

    logic [pts_pkg::WORD_W-1:0] w_rdata;
    logic [pts_pkg::WORD_W-1:0] w_wdata;
    logic                       w_we;
    logic [31:0]                w_dl;
    logic [23:0]                w_per;
    logic [31:0]                w_utag;
    logic [31:0]                w_diff;
    logic                       w_due;
    logic                       w_out_free;
    logic                       w_emit;
    logic [IW-1:0]              w_rm_idx;
    logic                       w_rm_ok;

    assign w_dl   = w_rdata[87:56];
    assign w_per  = w_rdata[55:32];
    assign w_utag = w_rdata[31:0];
    assign w_diff = r_now - w_dl;
    assign w_due  = r_in_use[r_idx] && !w_diff[31];

    assign w_out_free = !r_o_valid || !i_stall;
    assign w_emit     = i_cmd.add_commit || i_cmd.add_full || i_cmd.remove_do
                        || (i_cmd.fire && r_hold_valid) || i_cmd.flush;

    assign w_rm_idx = IW'(r_slot);
    assign w_rm_ok  = (32'(r_slot) < SLOTS);

    assign w_we    = i_cmd.add_commit || (i_cmd.fire && !r_one_shot[r_idx]);
    assign w_wdata = i_cmd.add_commit ? {r_now, r_ivl, r_tag}
                                      : {w_dl + {8'd0, w_per}, w_per, w_utag};

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.load) begin
            n_idx = '0;
        end else if (i_cmd.advance) begin
            n_idx = r_idx + 1'b1;
        end
    end

    pts_ram #(
        .WIDTH (pts_pkg::WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_raddr (n_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_ivl  <= i_interval_ms;
            r_slot <= i_slot;
            r_tag  <= i_tag;
            r_now  <= i_now_ms;
        end
        if (i_cmd.fire) begin
            r_hold_idx <= r_idx;
            r_hold_tag <= w_utag;
        end
        if (w_emit) begin
            if (i_cmd.add_commit) begin
                r_o_status <= pts_pkg::ST_ADDED;
                r_o_slot   <= 4'(r_idx);
                r_o_tag    <= '0;
                r_o_last   <= 1'b1;
            end else if (i_cmd.add_full) begin
                r_o_status <= pts_pkg::ST_FULL;
                r_o_slot   <= '0;
                r_o_tag    <= '0;
                r_o_last   <= 1'b1;
            end else if (i_cmd.remove_do) begin
                r_o_status <= pts_pkg::ST_REMOVED;
                r_o_slot   <= r_slot;
                r_o_tag    <= '0;
                r_o_last   <= 1'b1;
            end else if (i_cmd.fire) begin
                r_o_status <= pts_pkg::ST_FIRED;
                r_o_slot   <= 4'(r_hold_idx);
                r_o_tag    <= r_hold_tag;
                r_o_last   <= 1'b0;
            end else if (r_hold_valid) begin
                r_o_status <= pts_pkg::ST_FIRED;
                r_o_slot   <= 4'(r_hold_idx);
                r_o_tag    <= r_hold_tag;
                r_o_last   <= 1'b1;
            end else begin
                r_o_status <= pts_pkg::ST_IDLE;
                r_o_slot   <= '0;
                r_o_tag    <= '0;
                r_o_last   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_cnt        <= '0;
            r_in_use     <= '0;
            r_one_shot   <= '0;
            r_hold_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.load) begin
                r_cnt        <= '0;
                r_hold_valid <= 1'b0;
            end else if (i_cmd.fire) begin
                r_cnt        <= r_cnt + 1'b1;
                r_hold_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hold_valid <= 1'b0;
            end
            if (i_cmd.add_commit) begin
                r_in_use[r_idx]   <= 1'b1;
                r_one_shot[r_idx] <= (r_kind == pts_pkg::K_ADD_ONE_SHOT) || (r_ivl == '0);
            end else if (i_cmd.remove_do && w_rm_ok) begin
                r_in_use[w_rm_idx] <= 1'b0;
            end else if (i_cmd.fire && r_one_shot[r_idx]) begin
                r_in_use[r_idx] <= 1'b0;
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_status.slot_free  = !r_in_use[r_idx];
    assign o_status.slot_due   = w_due;
    assign o_status.idx_end    = (r_idx == IW'(SLOTS - 1));
    assign o_status.cnt_last   = (r_cnt == CW'(pts_pkg::MAX_OUT - 1));
    assign o_status.hold_valid = r_hold_valid;
    assign o_status.out_free   = w_out_free;

    assign o_valid       = r_o_valid;
    assign o_status_code = r_o_status;
    assign o_slot_id     = r_o_slot;
    assign o_fired_tag   = r_o_tag;
    assign o_last        = r_o_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_emit && !w_out_free))
        else $error("result register loaded while a result is still waiting");

    a_fire_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire |-> w_due)
        else $error("slot fired while not due");

    a_hold_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> (r_cnt != '0))
        else $error("held fire without a fire count");

endmodule

/* sv/periodic_timer_slot_table.sv */
// Periodic timer slot table: top level joining the scan controller and the slot datapath.
// Processes one transaction at a time. An accepted transaction is first captured; then a
// remove reports its slot, an add walks the slots from slot 0 one per cycle until it finds
// a free one or reaches the last slot, and a dispatch walks every slot one per cycle
// (stopping once 16 slots fire, waiting while a due slot meets a stalled output), then
// flushes its final result. Fired periodic slots get their new deadline written back; a
// stalled output delays each result until taken. Results of a dispatch come out in slot
// order, one per due slot, with last set on the final one, or a single nothing-due result.
module periodic_timer_slot_table #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [23:0] i_interval_ms,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_tag,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot_id,
    output logic [31:0] o_fired_tag,
    output logic        o_last
);

    pts_pkg::t_dp_cmd    w_cmd;
    pts_pkg::t_dp_status w_status;

    pts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .i_status (w_status),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    pts_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_kind        (i_kind),
        .i_interval_ms (i_interval_ms),
        .i_slot        (i_slot),
        .i_tag         (i_tag),
        .i_now_ms      (i_now_ms),
        .i_stall       (i_stall),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_status_code (o_status),
        .o_slot_id     (o_slot_id),
        .o_fired_tag   (o_fired_tag),
        .o_last        (o_last)
    );

endmodule

/* sim/tb_periodic_timer_slot_table.sv */
// Self-checking testbench for the periodic timer slot table: directed and random transactions.
`timescale 1ns / 100ps

module tb_periodic_timer_slot_table;

    localparam int NUM_SLOTS   = 16;
    localparam int TAIL_CYCLES = NUM_SLOTS + 8;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  slot_id;
        logic [31:0] fired_tag;
        logic        last;
    } t_timer_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind = pts_pkg::K_ADD_PERIODIC;
    logic [23:0] i_interval_ms = '0;
    logic [3:0]  i_slot = '0;
    logic [31:0] i_tag = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [3:0]  o_slot_id;
    logic [31:0] o_fired_tag;
    logic        o_last;

    logic        tbl_used[NUM_SLOTS];
    logic        tbl_once[NUM_SLOTS];
    logic [31:0] tbl_deadline[NUM_SLOTS];
    logic [23:0] tbl_period[NUM_SLOTS];
    logic [31:0] tbl_tag[NUM_SLOTS];

    t_timer_result expected_results[$];

    logic        idle_on = 1'b1;
    logic [31:0] sim_ms = '0;
    int          errors = 0;
    int          items_sent = 0;
    int          directed_items = 0;
    int          results_checked = 0;
    int          fires_predicted = 0;
    int          full_predicted = 0;
    int          cycle_cnt = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          stall_left = 0;

    periodic_timer_slot_table #(
        .SLOTS(NUM_SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_kind(i_kind),
        .i_interval_ms(i_interval_ms),
        .i_slot(i_slot),
        .i_tag(i_tag),
        .i_now_ms(i_now_ms),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_slot_id(o_slot_id),
        .o_fired_tag(o_fired_tag),
        .o_last(o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
        errors++;
    endtask

    task automatic predict_timer_results(input logic [1:0] kind, input logic [23:0] ivl,
                                         input logic [3:0] slot, input logic [31:0] tag,
                                         input logic [31:0] now);
        t_timer_result res;
        t_timer_result fires[pts_pkg::MAX_OUT];
        int            n;
        int            free_idx;
        logic [31:0]   diff;
        n = 0;
        free_idx = -1;
        res.status = pts_pkg::ST_IDLE;
        res.slot_id = '0;
        res.fired_tag = '0;
        res.last = 1'b1;
        case (kind)
            pts_pkg::K_ADD_PERIODIC, pts_pkg::K_ADD_ONE_SHOT: begin
                for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                    if (!tbl_used[i]) free_idx = i;
                end
                if (free_idx < 0) begin
                    res.status = pts_pkg::ST_FULL;
                    full_predicted++;
                end else begin
                    tbl_used[free_idx] = 1'b1;
                    tbl_once[free_idx] = (kind == pts_pkg::K_ADD_ONE_SHOT) || (ivl == '0);
                    tbl_deadline[free_idx] = now;
                    tbl_period[free_idx] = ivl;
                    tbl_tag[free_idx] = tag;
                    res.status = pts_pkg::ST_ADDED;
                    res.slot_id = 4'(free_idx);
                end
                expected_results.push_back(res);
            end
            pts_pkg::K_REMOVE: begin
                if (int'(slot) < NUM_SLOTS) tbl_used[slot] = 1'b0;
                res.status = pts_pkg::ST_REMOVED;
                res.slot_id = slot;
                expected_results.push_back(res);
            end
            default: begin
                for (int i = 0; i < NUM_SLOTS && n < pts_pkg::MAX_OUT; i++) begin
                    diff = now - tbl_deadline[i];
                    if (tbl_used[i] && !diff[31]) begin
                        fires[n].status = pts_pkg::ST_FIRED;
                        fires[n].slot_id = 4'(i);
                        fires[n].fired_tag = tbl_tag[i];
                        fires[n].last = 1'b0;
                        n++;
                        if (tbl_once[i]) tbl_used[i] = 1'b0;
                        else tbl_deadline[i] = tbl_deadline[i] + {8'h00, tbl_period[i]};
                    end
                end
                if (n == 0) begin
                    expected_results.push_back(res);
                end else begin
                    fires[n - 1].last = 1'b1;
                    for (int k = 0; k < n; k++) expected_results.push_back(fires[k]);
                    fires_predicted += n;
                end
            end
        endcase
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [23:0] ivl,
                             input logic [3:0] slot, input logic [31:0] tag,
                             input logic [31:0] now);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_interval_ms <= ivl;
        i_slot <= slot;
        i_tag <= tag;
        i_now_ms <= now;
        do @(posedge i_clk); while (o_stall);
        predict_timer_results(kind, ivl, slot, tag, now);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_interval();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return 24'hFFFFFF;
        if (r == 2) return 24'($urandom);
        return 24'($urandom_range(1, 60));
    endfunction

    function automatic logic [3:0] pick_slot();
        int cand[$];
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_used[i]) cand.push_back(i);
        end
        if (cand.size() == 0 || $urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
        return 4'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    task automatic send_random(input int count);
        int r;
        for (int j = 0; j < count; j++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_item(2'($urandom), 24'($urandom), 4'($urandom), $urandom, $urandom);
            end else if (r < 40) begin
                send_item(r < 20 ? pts_pkg::K_ADD_ONE_SHOT : pts_pkg::K_ADD_PERIODIC,
                          pick_interval(), 4'($urandom), $urandom,
                          sim_ms - $urandom_range(0, 20));
            end else if (r < 58) begin
                send_item(pts_pkg::K_REMOVE, 24'($urandom), pick_slot(), $urandom, $urandom);
            end else begin
                if ($urandom_range(0, 19) == 0) sim_ms = sim_ms + $urandom;
                else sim_ms = sim_ms + $urandom_range(0, 40);
                send_item(pts_pkg::K_DISPATCH, 24'($urandom), 4'($urandom), $urandom, sim_ms);
            end
        end
    endtask

    task automatic test_add_remove_basics();
        send_item(pts_pkg::K_ADD_PERIODIC, 24'h000000, 4'h0, 32'h0000_0000, 32'h0000_0000);
        send_item(pts_pkg::K_ADD_ONE_SHOT, 24'hFFFFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_item(pts_pkg::K_ADD_PERIODIC, 24'hFFFFFF, 4'h0, 32'hA5A5_A5A5, 32'h0000_0010);
        send_item(pts_pkg::K_DISPATCH, 24'h000000, 4'h0, 32'h0000_0000, 32'h0000_000F);
        send_item(pts_pkg::K_DISPATCH, 24'hFFFFFF, 4'hF, 32'hFFFF_FFFF, 32'h0000_000F);
        send_item(pts_pkg::K_DISPATCH, 24'h000000, 4'h0, 32'h0000_0000, 32'h0000_0010);
        send_item(pts_pkg::K_REMOVE, 24'h000000, 4'hF, 32'h0000_0000, 32'h0000_0000);
        send_item(pts_pkg::K_REMOVE, 24'hFFFFFF, 4'h2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(pts_pkg::K_DISPATCH, 24'h000000, 4'h0, 32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            send_item(pts_pkg::K_ADD_PERIODIC, 24'(i + 1), 4'($urandom), $urandom, 32'd100);
        end
        send_item(pts_pkg::K_ADD_ONE_SHOT, 24'd5, 4'h0, $urandom, 32'd100);
        send_item(pts_pkg::K_DISPATCH, 24'h000000, 4'h0, 32'h0000_0000, 32'd100);
    endtask

    task automatic test_random_traffic();
        sim_ms = 32'hFFFF_FC00;
        send_random(60);
    endtask

    task automatic test_backpressure();
        hold_requests++;
        send_random(20);
        wait_drained();
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        send_random(25);
    endtask

    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(o_status), 32'hFFFF_FFFF);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_slot_id !== want.slot_id)
                    report_mismatch("slot_id", 32'(o_slot_id), 32'(want.slot_id));
                if (o_fired_tag !== want.fired_tag)
                    report_mismatch("fired_tag", o_fired_tag, want.fired_tag);
                if (o_last !== want.last)
                    report_mismatch("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_used[i] = 1'b0;
            tbl_once[i] = 1'b0;
            tbl_deadline[i] = '0;
            tbl_period[i] = '0;
            tbl_tag[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_add_remove_basics();
        test_full_table();
        directed_items = items_sent;
        test_random_traffic();
        test_backpressure();
        test_steady_stream();
        wait_drained();

        $display("sent %0d transactions (%0d directed), checked %0d results",
                 items_sent, directed_items, results_checked);
        $display("predicted %0d slot fires and %0d table-full reports, %0d mismatches",
                 fires_predicted, full_predicted, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
